// ----- rtl/nchash_pkg.sv -----
// Package for the n-gram counting hash table: types, codes and constants.
package nchash_pkg;

  localparam int DEF_SLOTS = 1024;
  localparam int KEY_WORDS = 4;
  localparam int KEY_LEN_W = 3;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 3'd3;

  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;   // prime is 2^40 + this
  localparam logic [63:0] MIX_C1 = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_C2 = 64'hC4CEB9FE1A85EC53;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_MISS    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_XOR, S_MUL, S_PRD, S_PWAIT, S_PCMP,
    S_RK, S_RKW, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key_word_0;
    logic [31:0] key_word_1;
    logic [31:0] key_word_2;
    logic [31:0] key_word_3;
    logic [63:0] delta;
    logic [9:0]  entry_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] count_value;
    logic [9:0]  entry_index;
    logic [31:0] out_word_0;
    logic [31:0] out_word_1;
    logic [31:0] out_word_2;
    logic [31:0] out_word_3;
  } out_item_t;

endpackage

// ----- rtl/ngram_count_hash_table_top.sv -----
// N-gram counting table with FNV-1a/fmix64 hash and linear probing.
//
// Requests arrive on in_valid/in_stall with an in_item_t payload: add delta
// to a key, get a key's count, or read back the key at an entry index.
// Each request gives one result on out_valid/out_stall (out_item_t).
// cfg_we/cfg_data write key_length (words hashed and compared, 1..4).
// One request is in work at a time; in_stall is high until it finishes.
// Steps per request: the key words are hashed in turn, the final mix runs on
// a shared 32x32 multiplier (three partial products per 64-bit multiply),
// then each probed slot takes slot, key and count memory reads and a compare,
// and a last step hands off. Read-key reads the key memory at the entry index.
// The result sits in an output register, so a new request is taken while the
// receiver stalls; a finished one waits there.
// After reset the slot table is swept clear, one slot a cycle, with in_stall
// high; configuration writes are taken meanwhile.
// SLOTS must be a power of two; the home slot is the low hash bits.
module ngram_count_hash_table_top
  import nchash_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [KEY_LEN_W-1:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int TW = SW + 1;
  localparam int MAX_KEYS = (7 * SLOTS) / 10;
  localparam int RW = 32 * KEY_WORDS;

  state_t state_r, state_nxt;

  logic [KEY_LEN_W-1:0] key_length_r;
  logic [63:0] h_r, h_nxt, acc_r, acc_nxt;
  logic [1:0]  xr_r, xr_nxt, ph_r, ph_nxt, w_r, w_nxt, nl_r, nl_nxt;
  logic [SW-1:0] s_r, s_nxt, clr_r, clr_nxt;
  logic [TW-1:0] t_r, t_nxt, total_r, total_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] k_r [KEY_WORDS], k_nxt [KEY_WORDS];
  logic [63:0] delta_r, delta_nxt;
  logic [9:0]  esel_r, esel_nxt;
  out_item_t   res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // memories
  logic [TW-1:0] slot_table [SLOTS];
  logic [63:0]   cnt_mem [SLOTS];
  logic [RW-1:0] key_mem [SLOTS];
  logic [TW-1:0] tab_q;
  logic [63:0]   cnt_q;
  logic [RW-1:0] key_q;

  logic          tab_we, key_we, cnt_we;
  logic [SW-1:0] tab_wa, key_wa, key_ra;
  logic [TW-1:0] tab_wd;
  logic [63:0]   cnt_wd;
  logic [RW-1:0] key_row;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_c;

  logic [2:0]  len_eff;
  logic [31:0] in_w [KEY_WORDS];
  logic [63:0] fnv_x;
  logic [SW-1:0] entry_hit;
  logic        key_match, rk_ok;
  logic [31:0] wd;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign len_eff = (key_length_r == 3'd0) ? 3'd1 :
                   (key_length_r > 3'(KEY_WORDS)) ? 3'(KEY_WORDS) : key_length_r;

  assign in_w[0] = in_data.key_word_0;
  assign in_w[1] = in_data.key_word_1;
  assign in_w[2] = in_data.key_word_2;
  assign in_w[3] = in_data.key_word_3;

  assign mul_c = (xr_r == 2'd0) ? MIX_C1 : MIX_C2;
  assign mul_a = (ph_r == 2'd2) ? h_r[63:32] : h_r[31:0];
  assign mul_b = (ph_r == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign fnv_x = h_r ^ {32'd0, k_r[w_r]};
  assign entry_hit = SW'(tab_q - TW'(1));

  always_comb begin
    key_match = 1'b1;
    for (int i = 0; i < KEY_WORDS; i++) begin
      if (2'(i) <= nl_r && key_q[32*i +: 32] != k_r[i]) key_match = 1'b0;
    end
  end

  assign rk_ok = ({22'd0, esel_r} < 32'(total_r)) && ({22'd0, esel_r} < 32'(SLOTS));

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) key_row[32*i +: 32] = k_r[i];
  end

  assign key_ra = (state_r == S_RK) ? SW'(esel_r) : entry_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == SW'(SLOTS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_READ) state_nxt = S_RK;
          else if (in_data.opcode == OP_ADD || in_data.opcode == OP_GET)
            state_nxt = S_HASH;
          else state_nxt = S_DONE;
        end
      end
      S_HASH:  if (w_r == nl_r) state_nxt = S_XOR;
      S_XOR:   state_nxt = (xr_r == 2'd2) ? S_PRD : S_MUL;
      S_MUL:   if (ph_r == 2'd2) state_nxt = S_XOR;
      S_PRD:   state_nxt = S_PWAIT;
      S_PWAIT: state_nxt = (tab_q == '0) ? S_DONE : S_PCMP;
      S_PCMP: begin
        if (key_match || t_r == TW'(SLOTS - 1)) state_nxt = S_DONE;
        else state_nxt = S_PRD;
      end
      S_RK:    state_nxt = rk_ok ? S_RKW : S_DONE;
      S_RKW:   state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    h_nxt = h_r; acc_nxt = acc_r; xr_nxt = xr_r; ph_nxt = ph_r; w_nxt = w_r;
    nl_nxt = nl_r; s_nxt = s_r; t_nxt = t_r; clr_nxt = clr_r;
    total_nxt = total_r; op_nxt = op_r; delta_nxt = delta_r; esel_nxt = esel_r;
    res_nxt = res_r;
    for (int i = 0; i < KEY_WORDS; i++) k_nxt[i] = k_r[i];
    tab_we = 1'b0; tab_wa = s_r; tab_wd = '0;
    key_we = 1'b0; key_wa = SW'(total_r);
    cnt_we = 1'b0; cnt_wd = delta_r;
    wd = '0;

    unique case (state_r)
      S_CLEAR: begin
        tab_we = 1'b1;
        tab_wa = clr_r;
        clr_nxt = clr_r + SW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.opcode;
          delta_nxt = in_data.delta;
          esel_nxt = in_data.entry_select;
          nl_nxt = 2'(len_eff - 3'd1);
          for (int i = 0; i < KEY_WORDS; i++)
            k_nxt[i] = (3'(i) < len_eff) ? in_w[i] : 32'd0;
          h_nxt = FNV_OFFSET;
          w_nxt = '0;
          xr_nxt = '0;
          ph_nxt = '0;
          t_nxt = '0;
          res_nxt = '0;
          res_nxt.status = ST_MISS;
        end
      end
      S_HASH: begin
        h_nxt = (fnv_x << 40) + (fnv_x * {55'd0, FNV_PRIME_LO});
        w_nxt = w_r + 2'd1;
      end
      S_XOR: begin
        h_nxt = h_r ^ (h_r >> 33);
        s_nxt = h_nxt[SW-1:0];
        ph_nxt = '0;
      end
      S_MUL: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd0) acc_nxt = mul_p;
        else if (ph_r == 2'd1) acc_nxt = acc_r + {mul_p[31:0], 32'd0};
        else begin
          h_nxt = acc_r + {mul_p[31:0], 32'd0};
          xr_nxt = xr_r + 2'd1;
        end
      end
      S_PRD: ;
      S_PWAIT: begin
        if (tab_q == '0) begin
          // empty slot: key is absent
          if (op_r == OP_ADD) begin
            if (32'(total_r) >= 32'(MAX_KEYS)) res_nxt.status = ST_FULL;
            else begin
              tab_we = 1'b1;
              tab_wd = total_r + TW'(1);
              key_we = 1'b1;
              cnt_we = 1'b1;
              cnt_wd = delta_r;
              total_nxt = total_r + TW'(1);
              res_nxt.status = ST_ADDED;
              res_nxt.count_value = delta_r;
              res_nxt.entry_index = 10'(total_r);
            end
          end
        end
      end
      S_PCMP: begin
        if (key_match) begin
          res_nxt.entry_index = 10'(entry_hit);
          if (op_r == OP_ADD) begin
            cnt_we = 1'b1;
            cnt_wd = cnt_q + delta_r;
            res_nxt.status = ST_UPDATED;
            res_nxt.count_value = cnt_q + delta_r;
          end else begin
            res_nxt.status = ST_FOUND;
            res_nxt.count_value = cnt_q;
          end
        end else if (t_r == TW'(SLOTS - 1)) begin
          if (op_r == OP_ADD) res_nxt.status = ST_FULL;
        end else begin
          s_nxt = (s_r == SW'(SLOTS - 1)) ? '0 : s_r + SW'(1);
          t_nxt = t_r + TW'(1);
        end
      end
      S_RK: ;
      S_RKW: begin
        res_nxt.status = ST_FOUND;
        res_nxt.entry_index = esel_r;
        res_nxt.out_word_0 = key_q[31:0];
        res_nxt.out_word_1 = (nl_r >= 2'd1) ? key_q[63:32] : wd;
        res_nxt.out_word_2 = (nl_r >= 2'd2) ? key_q[95:64] : wd;
        res_nxt.out_word_3 = (nl_r >= 2'd3) ? key_q[127:96] : wd;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_nxt = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      key_length_r <= KEY_LEN_RST;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      total_r <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) key_length_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt; acc_r <= acc_nxt; xr_r <= xr_nxt; ph_r <= ph_nxt;
    w_r <= w_nxt; nl_r <= nl_nxt; s_r <= s_nxt; t_r <= t_nxt;
    op_r <= op_nxt; delta_r <= delta_nxt; esel_r <= esel_nxt;
    res_r <= res_nxt; out_r <= out_nxt;
    for (int i = 0; i < KEY_WORDS; i++) k_r[i] <= k_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (tab_we) slot_table[tab_wa] <= tab_wd;
    tab_q <= slot_table[s_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[s_r] <= cnt_wd;
    cnt_q <= cnt_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_row;
    key_q <= key_mem[key_ra];
  end

endmodule
